[rtl/c_string_unescape_decoder_macros.svh]
// Assertion macros used by the checker file.
`ifndef C_STRING_UNESCAPE_DECODER_MACROS_SVH
`define C_STRING_UNESCAPE_DECODER_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define CSUD_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("csud check failed");

// Check that cond implies prop in the next cycle.
`define CSUD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("csud check failed");

// Check that cond implies prop in the next cycle, with no reset gating.
`define CSUD_ASSERT_ALWAYS(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("csud check failed");

`endif

[rtl/csud_pkg.sv]
`default_nettype none
package csud_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int OUT_LEN_W   = 16;

   localparam logic [7:0] CHR_NUL       = 8'h00;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHR_QUOTE     = 8'h27;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHR_ZERO      = 8'h30;
   localparam logic [7:0] CHR_SEVEN     = 8'h37;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 has_byte;
      logic                 string_done;
      logic [OUT_LEN_W-1:0] out_length;
      logic                 run_last;
   } rsp_item_type;

   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esc_type;

   // Hex digit value; valid bit on top.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   // Single-character escapes.
   function automatic esc_type named_escape(input logic [7:0] c);
      esc_type r;
      r.valid = 1'b1;
      r.value = c;
      unique case (c)
         8'h61: r.value = 8'd7;
         8'h62: r.value = 8'd8;
         8'h66: r.value = 8'd12;
         8'h6E: r.value = 8'd10;
         8'h72: r.value = 8'd13;
         8'h74: r.value = 8'd9;
         8'h76: r.value = 8'd11;
         CHR_BACKSLASH, CHR_QUESTION, CHR_QUOTE, CHR_DQUOTE: r.value = c;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/csud_engine.sv]
`default_nettype none
module csud_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_byte,
   input  wire logic               req_last,
   input  wire logic               room,
   output csud_pkg::push_type      push
);
   import csud_pkg::*;

   localparam logic [2:0] MODE_TEXT   = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_OCT    = 3'd2;
   localparam logic [2:0] MODE_XSTART = 3'd3;
   localparam logic [2:0] MODE_HEX    = 3'd4;

   localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic [2:0]             mode_ff, mode_in;
   logic [7:0]             pend_ff, pend_in;
   logic [1:0]             odig_ff, odig_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic       fire;
   logic [2:0] mode_mid;
   logic [7:0] pend_mid;
   logic [1:0] odig_mid;
   logic       e0_v, e1_v, fl_v, as_text, end_v;
   logic [7:0] e0_b, b;
   logic       r0_v, r1_v;
   logic [7:0] r0_b, r1_b;
   logic [4:0] hv;
   esc_type    esc;
   logic [LENGTH_BITS-1:0] cnt1, cnt2;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tvalid && req_tready ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign b           = in_byte_ff;
   assign hv          = hex_digit(b);
   assign esc         = named_escape(b);

   always_comb begin
      mode_mid = mode_ff;
      pend_mid = pend_ff;
      odig_mid = odig_ff;
      e0_v     = 1'b0;
      e0_b     = 8'd0;
      as_text  = 1'b0;
      unique case (mode_ff)
         MODE_ESC: begin
            mode_mid = MODE_TEXT;
            if (esc.valid) begin
               e0_v = 1'b1;
               e0_b = esc.value;
            end else if (b == CHR_LOWER_X || b == CHR_UPPER_X) begin
               mode_mid = MODE_XSTART;
            end else if (b >= CHR_ZERO && b <= CHR_SEVEN) begin
               pend_mid = {5'd0, b[2:0]};
               odig_mid = 2'd1;
               mode_mid = MODE_OCT;
            end
         end
         MODE_OCT: begin
            if (b >= CHR_ZERO && b <= CHR_SEVEN) begin
               pend_mid = {pend_ff[4:0], b[2:0]};
               odig_mid = odig_ff + 2'd1;
               // third digit closes the escape at once
               if (odig_ff >= 2'd2) begin
                  e0_v     = 1'b1;
                  e0_b     = {pend_ff[4:0], b[2:0]};
                  mode_mid = MODE_TEXT;
                  pend_mid = 8'd0;
                  odig_mid = 2'd0;
               end
            end else begin
               e0_v     = 1'b1;
               e0_b     = pend_ff;
               mode_mid = MODE_TEXT;
               pend_mid = 8'd0;
               odig_mid = 2'd0;
               as_text  = 1'b1;
            end
         end
         MODE_XSTART: begin
            if (hv[4]) begin
               pend_mid = {4'd0, hv[3:0]};
               mode_mid = MODE_HEX;
            end else begin
               mode_mid = MODE_TEXT;
               as_text  = 1'b1;
            end
         end
         MODE_HEX: begin
            if (hv[4]) begin
               pend_mid = {pend_ff[3:0], hv[3:0]};
            end else begin
               e0_v     = 1'b1;
               e0_b     = pend_ff;
               mode_mid = MODE_TEXT;
               pend_mid = 8'd0;
               as_text  = 1'b1;
            end
         end
         default: begin
            mode_mid = MODE_TEXT;
            as_text  = 1'b1;
         end
      endcase

      e1_v = 1'b0;
      if (as_text && b != CHR_NUL) begin
         if (b == CHR_BACKSLASH) mode_mid = MODE_ESC;
         else e1_v = 1'b1;
      end
   end

   assign end_v = (b == CHR_NUL) || in_last_ff;
   assign fl_v  = end_v && (mode_mid == MODE_OCT || mode_mid == MODE_HEX);

   // pick the first two of: escape result, plain byte, flushed value
   always_comb begin
      r0_v = e0_v || e1_v || fl_v;
      r0_b = e0_v ? e0_b : (e1_v ? b : pend_mid);
      r1_v = (e0_v && (e1_v || fl_v)) || (e1_v && fl_v);
      r1_b = (e0_v && e1_v) ? b : pend_mid;
   end

   assign cnt1 = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + 1'b1;

   always_comb begin
      push.push0 = fire && (r0_v || end_v);
      push.push1 = fire && r1_v;
      push.item0.out_byte    = r0_v ? r0_b : 8'd0;
      push.item0.has_byte    = r0_v;
      push.item0.string_done = end_v && !r1_v;
      push.item0.out_length  = OUT_LEN_W'(r0_v ? cnt1 : count_ff);
      push.item0.run_last    = !r1_v;
      push.item1.out_byte    = r1_b;
      push.item1.has_byte    = 1'b1;
      push.item1.string_done = end_v;
      push.item1.out_length  = OUT_LEN_W'(cnt2);
      push.item1.run_last    = 1'b1;
   end

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      odig_in  = odig_ff;
      count_in = count_ff;
      if (fire) begin
         if (end_v) begin
            mode_in  = MODE_TEXT;
            pend_in  = 8'd0;
            odig_in  = 2'd0;
            count_in = '0;
         end else begin
            mode_in  = mode_mid;
            pend_in  = pend_mid;
            odig_in  = odig_mid;
            count_in = r1_v ? cnt2 : (r0_v ? cnt1 : count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_TEXT;
         pend_ff     <= 8'd0;
         odig_ff     <= 2'd0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         odig_ff     <= odig_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
   end

endmodule
`default_nettype wire

[rtl/csud_rsp_queue.sv]
`default_nettype none
module csud_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csud_pkg::push_type    push,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output csud_pkg::rsp_item_type     rsp_item
);
   import csud_pkg::*;

   rsp_item_type slot_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   fill_ff, fill_in;
   logic         pop;
   logic [1:0]   wr_next;

   // room for a full two-item push
   assign room      = fill_ff <= 3'd2;
   assign rsp_valid = fill_ff != 3'd0;
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push.push0} + {1'b0, push.push1};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      fill_in   = fill_ff + {2'd0, push.push0} + {2'd0, push.push1} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         fill_ff   <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) slot_ff[wr_ptr_ff] <= push.item0;
      if (push.push1) slot_ff[wr_next] <= push.item1;
   end

endmodule
`default_nettype wire

[rtl/c_string_unescape_decoder.sv]
// Path: an accepted byte is held in the input register and decoded; its results are
// written into the result queue once that queue has room, and the output reads from it.
// Throughput: one byte per cycle while the result queue has room; a byte may yield two
// results, and the four-entry result queue stops intake when it cannot take two.
// Reset: synchronous, active high; returns to plain-text mode with zero length
// and empties the result queue.
`default_nettype none
module c_string_unescape_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] out_length
   output logic [1:0]       rsp_tuser,   // [0] has_byte, [1] string_done
   output logic             rsp_tlast    // run_last
);
   import csud_pkg::*;

   push_type     push;
   logic         room;
   rsp_item_type item;

   csud_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .room       (room),
      .push       (push)
   );

   csud_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (item)
   );

   assign rsp_tdata = {item.out_length, item.out_byte};
   assign rsp_tuser = {item.string_done, item.has_byte};
   assign rsp_tlast = item.run_last;

endmodule
`default_nettype wire

[rtl/csud_checker.sv]
`default_nettype none
`include "c_string_unescape_decoder_macros.svh"
module csud_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   logic rsp_empty;
   logic rsp_empty_ok;

   assign rsp_empty    = rsp_tvalid && !rsp_tuser[0];
   assign rsp_empty_ok = rsp_tuser[1] && rsp_tdata[7:0] == 8'd0;

   // no result right after reset
   `CSUD_ASSERT_ALWAYS(a_idle_after_reset, clock, reset, !rsp_tvalid)
   // a result that carries no byte only closes a string
   `CSUD_ASSERT_IMPLY(a_empty_is_done, clock, reset, rsp_empty, rsp_empty_ok)
   // the closing result is the last one of its item
   `CSUD_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast)
   // hold a stalled result
   `CSUD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind c_string_unescape_decoder csud_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
